FILE: hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Character codes and shift-and-add-3 constants for the number to text block.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    // ASCII bases for digits and hex letters.
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;

    // Decimal radix; a nibble at or above it is a hex letter.
    localparam logic [3:0] DEC_RADIX = 4'd10;

    // Shift-and-add-3: a BCD digit at or above five gets three added.
    localparam logic [3:0] DAB_ADJ_MIN = 4'd5;
    localparam logic [3:0] DAB_ADJ     = 4'd3;

    // Binary bits consumed by each full conversion stage.
    localparam int BITS_PER_STAGE = 4;

endpackage : itoa_pkg

`default_nettype wire

FILE: hdl/itoa_dabble.sv
// ----------------------------------------------------------------------------
// itoa_dabble
// Pipelined binary to BCD converter; a stage runs up to four shift-and-add-3
// steps. The value and mode bits travel alongside for the hex path.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10,
    parameter int HEX_W      = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input words
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [VALUE_BITS-1:0]   i_value,
    input  wire logic                    i_hex_mode,
    input  wire logic                    i_lower_case,
    // Converted words
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [4*DIGITS-1:0]          o_bcd,
    output logic [HEX_W-1:0]             o_val,
    output logic                         o_hex,
    output logic                         o_low
);

    localparam int BPS    = itoa_pkg::BITS_PER_STAGE;
    localparam int STAGES = (VALUE_BITS + BPS - 1) / BPS;
    localparam int ACC_W  = 4 * DIGITS + VALUE_BITS;

    logic [ACC_W-1:0] r_acc [STAGES];
    logic [HEX_W-1:0] r_val [STAGES];
    logic             r_hex [STAGES];
    logic             r_low [STAGES];
    logic             r_v   [STAGES];
    logic             w_en  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int NSTEP = ((s + 1) * BPS <= VALUE_BITS) ? BPS : VALUE_BITS - s * BPS;

        logic [ACC_W-1:0] w_in_acc;
        logic [HEX_W-1:0] w_in_val;
        logic             w_in_hex;
        logic             w_in_low;
        logic             w_in_v;
        logic [ACC_W-1:0] n_acc;

        // Stage input comes from the port or from the previous stage.
        if (s == 0) begin : g_first
            assign w_in_acc = ACC_W'(i_value);
            assign w_in_val = HEX_W'(i_value);
            assign w_in_hex = i_hex_mode;
            assign w_in_low = i_lower_case;
            assign w_in_v   = i_valid;
        end else begin : g_next
            assign w_in_acc = r_acc[s-1];
            assign w_in_val = r_val[s-1];
            assign w_in_hex = r_hex[s-1];
            assign w_in_low = r_low[s-1];
            assign w_in_v   = r_v[s-1];
        end

        // A stage loads when it is empty or its word moves on.
        if (s == STAGES - 1) begin : g_last
            assign w_en[s] = !r_v[s] || i_ready;
        end else begin : g_mid
            assign w_en[s] = !r_v[s] || w_en[s+1];
        end

        // Shift-and-add-3 steps for this stage's share of bits.
        always_comb begin
            logic [ACC_W-1:0] x;
            x = w_in_acc;
            for (int k = 0; k < NSTEP; k++) begin
                for (int d = 0; d < DIGITS; d++) begin
                    if (x[VALUE_BITS + 4*d +: 4] >= itoa_pkg::DAB_ADJ_MIN) begin
                        x[VALUE_BITS + 4*d +: 4] = x[VALUE_BITS + 4*d +: 4] + itoa_pkg::DAB_ADJ;
                    end
                end
                x = x << 1;
            end
            n_acc = x;
        end

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= w_in_v;
            end
        end

        // Payload of the stage.
        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_acc[s] <= n_acc;
                r_val[s] <= w_in_val;
                r_hex[s] <= w_in_hex;
                r_low[s] <= w_in_low;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[STAGES-1];
    assign o_bcd   = r_acc[STAGES-1][ACC_W-1 -: 4*DIGITS];
    assign o_val   = r_val[STAGES-1];
    assign o_hex   = r_hex[STAGES-1];
    assign o_low   = r_low[STAGES-1];

endmodule : itoa_dabble

`default_nettype wire

FILE: hdl/integer_to_ascii_dec_hex.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_dec_hex
// Renders an unsigned number as ASCII decimal or byte-wise hex text, one
// character per output word, most significant first, last on the final one.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------
//  input   | i_valid / o_ready  | i_value, i_hex_mode, i_lower_case
//  output  | o_valid / i_ready  | o_character, o_last
//
//  A word passes ceil(VALUE_BITS/4) conversion stages (8 at 32 bits), then a
//  serializer gives one character per cycle, unless stalled, through the
//  single output character port; a word gives 1 to 10 characters at 32 bits.
//  The serializer takes the next word in the cycle its final character moves
//  to the output register. Reset clears all valid bits and the serializer.
//  A stall at the output holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_dec_hex #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_hex_mode,
    input  wire logic                  i_lower_case,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [6:0]                 o_character,
    output logic                       o_last
);

    localparam int DIGITS    = (VALUE_BITS * 77) / 256 + 1;
    localparam int HEX_BYTES = (VALUE_BITS + 7) / 8;
    localparam int HEX_W     = HEX_BYTES * 8;
    localparam int MAX_CHARS = (DIGITS > 2 * HEX_BYTES) ? DIGITS : 2 * HEX_BYTES;
    localparam int IW        = $clog2(MAX_CHARS);

    logic [4*DIGITS-1:0] w_bcd;
    logic [HEX_W-1:0]    w_val;
    logic                w_hex;
    logic                w_low;
    logic                w_valid;
    logic                w_ready;

    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS),
        .HEX_W      (HEX_W)
    ) u_dabble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_hex_mode   (i_hex_mode),
        .i_lower_case (i_lower_case),
        .o_valid      (w_valid),
        .i_ready      (w_ready),
        .o_bcd        (w_bcd),
        .o_val        (w_val),
        .o_hex        (w_hex),
        .o_low        (w_low)
    );

    logic                r_busy;
    logic [IW-1:0]       r_idx;
    logic [4*DIGITS-1:0] r_bcd;
    logic [HEX_W-1:0]    r_val;
    logic                r_hex;
    logic                r_low;
    logic                w_out_load;
    logic [IW-1:0]       w_first_idx;
    logic [3:0]          w_nib;
    logic [6:0]          w_char;

    // While the serializer holds a word, the output register loads whenever it is empty or being taken.
    assign w_out_load = r_busy && (!o_valid || i_ready);
    assign w_ready    = !r_busy || (w_out_load && (r_idx == '0));

    // Index of the first character: highest nonzero digit or byte.
    always_comb begin
        w_first_idx = '0;
        if (w_hex) begin
            w_first_idx = IW'(1);
            for (int b = 0; b < HEX_BYTES; b++) begin
                if (w_val[8*b +: 8] != 8'h00) begin
                    w_first_idx = IW'(2 * b + 1);
                end
            end
        end else begin
            for (int d = 0; d < DIGITS; d++) begin
                if (w_bcd[4*d +: 4] != 4'h0) begin
                    w_first_idx = IW'(d);
                end
            end
        end
    end

    // Current nibble and its character code.
    always_comb begin
        w_nib = r_hex ? r_val[4*r_idx +: 4] : r_bcd[4*r_idx +: 4];
        if (!r_hex || (w_nib < itoa_pkg::DEC_RADIX)) begin
            w_char = itoa_pkg::ASCII_ZERO + 7'(w_nib);
        end else begin
            w_char = (r_low ? itoa_pkg::ASCII_LOWER_A : itoa_pkg::ASCII_UPPER_A)
                     + 7'(w_nib - itoa_pkg::DEC_RADIX);
        end
    end

    // Serializer control and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (w_valid && w_ready) begin
                r_busy <= 1'b1;
                r_idx  <= w_first_idx;
            end else if (w_out_load) begin
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx - IW'(1);
                end
            end
        end
    end

    // Serializer payload and output characters.
    always_ff @(posedge i_clk) begin
        if (w_valid && w_ready) begin
            r_bcd <= w_bcd;
            r_val <= w_val;
            r_hex <= w_hex;
            r_low <= w_low;
        end
        if (w_out_load) begin
            o_character <= w_char;
            o_last      <= (r_idx == '0);
        end
    end

`ifndef ASSERT_OFF
    // The character index never runs past the widest text.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < IW'(MAX_CHARS)))
        else $error("character index out of range");

    // After a non-final character is taken, the next one is ready at once.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> o_valid)
        else $error("gap inside a word's text");

    // Every character is a digit or a hex letter.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character >= 7'h30 && o_character <= 7'h39) ||
                     (o_character >= 7'h41 && o_character <= 7'h46) ||
                     (o_character >= 7'h61 && o_character <= 7'h66)))
        else $error("character outside digit and hex letter set");
`endif

endmodule : integer_to_ascii_dec_hex

`default_nettype wire
